### rtl/b64d_pkg.sv
// shared types, status codes and character tables for the base64 stream decoder
// no dependencies; used by b64d_group, b64d_fifo and base64_stream_decoder_core

package b64d_pkg;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_CHAR   = 3'd1;
    localparam logic [2:0] ST_AFTER_PAD  = 3'd2;
    localparam logic [2:0] ST_MISPLACED  = 3'd3;
    localparam logic [2:0] ST_INCOMPLETE = 3'd4;

    localparam logic [7:0] CHAR_PAD = 8'h3d;

    localparam int FIFO_DEPTH_DEFAULT = 8;
    localparam int BURST_MAX          = 3;

    typedef struct packed {
        logic       last;
        logic [2:0] status_code;
        logic [7:0] data_byte;
        logic       is_status;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    e2;
        result_t    e1;
        result_t    e0;
    } burst_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } sextet_t;

    function automatic sextet_t sextet_lookup(input logic [7:0] c);
        sextet_t s;
        s.ok    = 1'b1;
        s.value = 6'd0;
        unique case (c) inside
            [8'h41:8'h5a]: s.value = 6'(c - 8'h41);
            [8'h61:8'h7a]: s.value = 6'(c - 8'h61 + 8'd26);
            [8'h30:8'h39]: s.value = 6'(c - 8'h30 + 8'd52);
            8'h2b:         s.value = 6'd62;
            8'h2f:         s.value = 6'd63;
            default:       s.ok    = 1'b0;
        endcase
        return s;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a);
    endfunction

endpackage

### rtl/b64d_group.sv
// group assembly and error tracking: consumes one transaction, emits a burst of results
// depends on b64d_pkg

module b64d_group
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic              operation,
    input  logic [7:0]        char_code,
    output b64d_pkg::burst_t  burst
);

    logic [5:0] vals_reg [4];
    logic [5:0] vals_next [4];
    logic [3:0] pads_reg, pads_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pad_seen_reg, pad_seen_next;
    logic [2:0] err_reg, err_next;

    b64d_pkg::sextet_t sx;
    logic              take;
    logic [5:0]        cur_v [4];
    logic [3:0]        cur_p;
    b64d_pkg::result_t r_none;

    always_comb
    begin
        sx = b64d_pkg::sextet_lookup(char_code);
        r_none = '0;
        burst = '0;
        burst.e0 = r_none;
        take = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            vals_next[i] = vals_reg[i];
            cur_v[i] = vals_reg[i];
        end
        pads_next = pads_reg;
        cnt_next = cnt_reg;
        pad_seen_next = pad_seen_reg;
        err_next = err_reg;
        cur_p = pads_reg;

        if (fire)
        begin
            if (operation == b64d_pkg::OP_END)
            begin
                burst.count = 2'd1;
                burst.e0.is_status = 1'b1;
                burst.e0.last = 1'b1;
                burst.e0.status_code = (err_reg == b64d_pkg::ST_OK && cnt_reg != 2'd0)
                                     ? b64d_pkg::ST_INCOMPLETE : err_reg;
                for (int i = 0; i < 4; i++)
                begin
                    vals_next[i] = 6'd0;
                end
                pads_next = 4'd0;
                cnt_next = 2'd0;
                pad_seen_next = 1'b0;
                err_next = b64d_pkg::ST_OK;
            end
            else if (err_reg != b64d_pkg::ST_OK || b64d_pkg::is_blank(char_code))
            begin
                take = 1'b0;
            end
            else if (char_code == b64d_pkg::CHAR_PAD)
            begin
                pad_seen_next = 1'b1;
                cur_v[cnt_reg] = 6'd0;
                cur_p[cnt_reg] = 1'b1;
                take = 1'b1;
            end
            else if (!sx.ok)
            begin
                err_next = b64d_pkg::ST_BAD_CHAR;
            end
            else if (pad_seen_reg)
            begin
                err_next = b64d_pkg::ST_AFTER_PAD;
            end
            else
            begin
                cur_v[cnt_reg] = sx.value;
                cur_p[cnt_reg] = 1'b0;
                take = 1'b1;
            end

            if (take)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    vals_next[i] = cur_v[i];
                end
                pads_next = cur_p;
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    if (cur_p[0] || cur_p[1] || (cur_p[2] && !cur_p[3]))
                    begin
                        err_next = b64d_pkg::ST_MISPLACED;
                    end
                    else
                    begin
                        burst.e0.data_byte = {cur_v[0], cur_v[1][5:4]};
                        burst.e1.data_byte = {cur_v[1][3:0], cur_v[2][5:2]};
                        burst.e2.data_byte = {cur_v[2][1:0], cur_v[3]};
                        burst.count = 2'd1 + {1'b0, !cur_p[2]} + {1'b0, !cur_p[3]};
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                vals_reg[i] <= 6'd0;
            end
            pads_reg <= 4'd0;
            cnt_reg <= 2'd0;
            pad_seen_reg <= 1'b0;
            err_reg <= b64d_pkg::ST_OK;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                vals_reg[i] <= vals_next[i];
            end
            pads_reg <= pads_next;
            cnt_reg <= cnt_next;
            pad_seen_reg <= pad_seen_next;
            err_reg <= err_next;
        end
    end

endmodule

### rtl/b64d_fifo.sv
// result queue: takes a burst of up to three results per cycle, drains one per transaction
// depends on b64d_pkg

module b64d_fifo
#(
    parameter int DEPTH = b64d_pkg::FIFO_DEPTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  b64d_pkg::burst_t  burst,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output b64d_pkg::result_t out_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    b64d_pkg::result_t mem [DEPTH];
    b64d_pkg::result_t ent [b64d_pkg::BURST_MAX];

    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          pop;

    assign ent[0] = burst.e0;
    assign ent[1] = burst.e1;
    assign ent[2] = burst.e2;

    assign out_valid  = (cnt_reg != '0);
    assign pop        = out_valid && out_ready;
    assign out_result = mem[rd_ptr_reg];
    assign room       = (cnt_reg <= CW'(DEPTH - b64d_pkg::BURST_MAX));

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < b64d_pkg::BURST_MAX; i++)
        begin
            if (i < int'(burst.count))
            begin
                mem[wr_ptr_reg + AW'(i)] <= ent[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + AW'(burst.count);
            rd_ptr_reg <= rd_ptr_reg + AW'(pop);
            cnt_reg <= cnt_reg + CW'(burst.count) - CW'(pop);
        end
    end

endmodule

### rtl/base64_stream_decoder_core.sv
// top level of the base64 stream decoder: input register, group decoder, result queue
// depends on b64d_pkg, b64d_group, b64d_fifo
//
// usage:
//   s_axis carries one text character per transaction (tdata) or, with tuser set,
//   an end-of-text marker. whitespace is skipped, each complete valid group of four
//   characters yields one to three data bytes on m_axis, and every end-of-text
//   transaction yields one status result with tlast set and tuser set.
//   data bytes stream out as soon as a group completes; when the closing status
//   is not ok the consumer drops the bytes of that text.
//   throughput: one character per cycle while the queue has room; each input
//   transaction is decoded combinationally between the input register and the
//   result queue, and the queue drains one result per cycle while the receiver
//   is ready, so four characters give at most three results.
//   when the receiver stalls the queue fills; s_axis_tready drops once the queue
//   cannot take a full burst of three results, and no result is lost.
//   reset empties the queue and the input register and clears the group state;
//   the block accepts input as soon as reset is released.
//   FIFO_DEPTH must be a power of two of at least 4.

module base64_stream_decoder_core
#(
    parameter int FIFO_DEPTH = b64d_pkg::FIFO_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tuser,   // [0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [10:8] status_code, rest zero
    output logic        m_axis_tuser,   // [0] is_status
    output logic        m_axis_tlast
);

    logic       in_valid_reg;
    logic       in_op_reg;
    logic [7:0] in_char_reg;
    logic       room;
    logic       fire;

    b64d_pkg::burst_t  burst;
    b64d_pkg::result_t head;

    assign fire = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg <= s_axis_tuser;
            in_char_reg <= s_axis_tdata;
        end
    end

    b64d_group u_group
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .operation (in_op_reg),
        .char_code (in_char_reg),
        .burst     (burst)
    );

    b64d_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .burst      (burst),
        .room       (room),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (head)
    );

    assign m_axis_tdata = {5'd0, head.status_code, head.data_byte};
    assign m_axis_tuser = head.is_status;
    assign m_axis_tlast = head.last;

endmodule
